FILE: src/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the 2x2 box downsampler
// Channel widths, geometry limits, register indexes and the lane control group.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // pixel format
  localparam int CH_BITS    = 8;
  localparam int LANE_BITS  = 9;
  localparam int NUM_LANES  = 4;
  localparam int PIX_BITS   = CH_BITS * NUM_LANES;

  // geometry
  localparam int CFG_W             = 13;
  localparam int CFG_IDX_W         = 1;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int ROW_W             = 12;
  localparam int DEFAULT_MAX_WIDTH = 4096;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } cfg_reg_t;

  // control group from the sequencer to every channel lane
  typedef struct packed {
    logic acc_load;  // capture even-column pixel
    logic a_load;    // advance stage a (pair sum register)
    logic b_load;    // advance stage b (output register)
    logic w_one;     // single-column source: pixel pairs with itself
    logic use_mem;   // stage a item takes its upper pair from the line store
  } lane_ctrl_t;

endpackage

FILE: src/rbd_lane.sv
// ----------------------------------------------------------------------------
// rbd_lane: one channel of the box filter
// Holds the even-column pixel, forms the horizontal pair sum, then adds the
// vertical partner and registers the truncated average.
// ----------------------------------------------------------------------------
module rbd_lane (
  input  logic                         clk,
  input  rbd_pkg::lane_ctrl_t          ctrl,
  input  logic [rbd_pkg::CH_BITS-1:0]  pix,
  input  logic [rbd_pkg::LANE_BITS-1:0] mem_pair,
  output logic [rbd_pkg::LANE_BITS-1:0] hsum,
  output logic [rbd_pkg::CH_BITS-1:0]  avg
);
  import rbd_pkg::*;

  logic [CH_BITS-1:0]   pair_acc_r;
  logic [LANE_BITS-1:0] hsum_a_r;
  logic [CH_BITS-1:0]   avg_r;
  logic [LANE_BITS-1:0] upper;
  logic [LANE_BITS:0]   box_sum;

  // horizontal pair sum
  assign hsum = {1'b0, pix} + {1'b0, (ctrl.w_one ? pix : pair_acc_r)};

  // vertical partner: line store or the same pair for a single-row source
  assign upper   = ctrl.use_mem ? mem_pair : hsum_a_r;
  assign box_sum = {1'b0, upper} + {1'b0, hsum_a_r};

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.acc_load) begin
      pair_acc_r <= pix;
    end
    if (ctrl.a_load) begin
      hsum_a_r <= hsum;
    end
    if (ctrl.b_load) begin
      avg_r <= box_sum[LANE_BITS:2];
    end
  end

  assign avg = avg_r;

endmodule

FILE: src/rbd_line_store.sv
// ----------------------------------------------------------------------------
// rbd_line_store: line store of horizontal pair sums
// Single-port memory, one access per enabled cycle, registered read data.
// ----------------------------------------------------------------------------
module rbd_line_store #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 36,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/rgba_box_downsample_2x2.sv
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2: next mip level of an RGBA8 stream by 2x2 box filter
// Four channel lanes in parallel, a pair-sum line store and a raster sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : source pixels in raster order, tdata = {alpha, blue, green, red}.
//   out_* : box averages in raster order of the output image; tlast marks the
//           last pixel of an output row, tuser the last pixel of the image.
//   cfg_* : src_width (index 0) and src_height (index 1), written while idle;
//           every write restarts the image at its first pixel.
// Throughput: one source pixel per clock while out_* is not stalled.
// Path: a pixel that completes a box passes stage a (with the line store read)
//   and then the output register before it shows on out_*.
// Output is max(1, W/2) by max(1, H/2); trailing odd columns and rows are
//   taken and dropped. Pixels of the odd source rows read the pair sums that
//   the row above left in the line store (MAX_WIDTH/2 entries, no clearing).
// Reset: counters clear, geometry returns to 1x1, pipeline empties.
// Stall: the whole pipe holds while out_tvalid is high and out_tready low;
//   in_tready follows, so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x2 #(
  parameter int MAX_WIDTH = rbd_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // source pixels: in_red, in_green, in_blue, in_alpha
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rbd_pkg::PIX_BITS-1:0]  in_tdata,
  // results: out_red, out_green, out_blue, out_alpha
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rbd_pkg::PIX_BITS-1:0]  out_tdata,
  output logic                          out_tlast,
  // results: end_of_image
  output logic                          out_tuser,
  // configuration
  input  logic                          cfg_wen,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::CFG_W-1:0]     cfg_wdata
);
  import rbd_pkg::*;

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = LANE_BITS * NUM_LANES;

  // geometry registers
  logic [CW-1:0]    w_m1_r, w_m1_nxt;
  logic [CW-1:0]    dst_w_m1_r, dst_w_m1_nxt;
  logic             w_one_r, w_one_nxt;
  logic [ROW_W-1:0] h_m1_r, h_m1_nxt;
  logic [ROW_W-1:0] dst_h_m1_r, dst_h_m1_nxt;
  logic             h_one_r, h_one_nxt;

  // raster position
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // pipeline control
  logic a_valid_r, a_valid_nxt;
  logic a_use_mem_r;
  logic a_eor_r, a_eoi_r;
  logic out_valid_r, out_valid_nxt;
  logic out_eor_r, out_eoi_r;

  logic en, accept;
  logic [CW:0]      eff_w;
  logic [CFG_W-1:0] eff_h;
  logic             col_odd, have_pair, have_out, store_we, rd_mem, acc_load;
  logic [AW-1:0]    x;
  logic [ROW_W-1:0] y;
  logic             eor, eoi;
  lane_ctrl_t       ctrl;
  logic [MW-1:0]    hsum_all, mem_rdata;
  logic [PIX_BITS-1:0] avg_all;

  assign en     = !out_valid_r || out_tready;
  assign accept = in_tvalid && en;
  assign in_tready = en;

  // effective geometry from the written value
  always_comb begin
    if (cfg_wdata == '0) begin
      eff_w = (CW+1)'(1);
    end else if (int'(cfg_wdata) > MAX_WIDTH) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(cfg_wdata);
    end
    if (cfg_wdata == '0) begin
      eff_h = CFG_W'(1);
    end else if (int'(cfg_wdata) > HEIGHT_LIMIT) begin
      eff_h = CFG_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = cfg_wdata;
    end
  end

  // register decode
  always_comb begin
    w_m1_nxt     = w_m1_r;
    dst_w_m1_nxt = dst_w_m1_r;
    w_one_nxt    = w_one_r;
    h_m1_nxt     = h_m1_r;
    dst_h_m1_nxt = dst_h_m1_r;
    h_one_nxt    = h_one_r;
    if (cfg_wen) begin
      unique case (cfg_index)
        REG_SRC_WIDTH: begin
          w_m1_nxt     = CW'(eff_w - 1'b1);
          w_one_nxt    = (eff_w == (CW+1)'(1));
          dst_w_m1_nxt = (eff_w == (CW+1)'(1)) ? '0 : CW'((eff_w >> 1) - 1'b1);
        end
        REG_SRC_HEIGHT: begin
          h_m1_nxt     = ROW_W'(eff_h - 1'b1);
          h_one_nxt    = (eff_h == CFG_W'(1));
          dst_h_m1_nxt = (eff_h == CFG_W'(1)) ? '0 : ROW_W'((eff_h >> 1) - 1'b1);
        end
        default: ;
      endcase
    end
  end

  // pairing decisions for the pixel at the input
  always_comb begin
    col_odd   = col_r[0];
    have_pair = w_one_r || col_odd;
    acc_load  = accept && !w_one_r && !col_odd && (col_r != w_m1_r);
    x         = w_one_r ? '0 : AW'(col_r >> 1);
    y         = h_one_r ? '0 : (row_r >> 1);
    rd_mem    = !h_one_r && row_r[0];
    store_we  = accept && have_pair && !h_one_r && !row_r[0] && (row_r != h_m1_r);
    have_out  = have_pair && (h_one_r || row_r[0]);
    eor       = (CW'(x) == dst_w_m1_r);
    eoi       = eor && (y == dst_h_m1_r);
  end

  // raster counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wen) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == w_m1_r) begin
        col_nxt = '0;
        row_nxt = (row_r == h_m1_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // valid flags through the pipe
  always_comb begin
    a_valid_nxt   = a_valid_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      a_valid_nxt   = accept && have_out;
      out_valid_nxt = a_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r      <= '0;
      dst_w_m1_r  <= '0;
      w_one_r     <= 1'b1;
      h_m1_r      <= '0;
      dst_h_m1_r  <= '0;
      h_one_r     <= 1'b1;
      col_r       <= '0;
      row_r       <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      w_m1_r      <= w_m1_nxt;
      dst_w_m1_r  <= dst_w_m1_nxt;
      w_one_r     <= w_one_nxt;
      h_m1_r      <= h_m1_nxt;
      dst_h_m1_r  <= dst_h_m1_nxt;
      h_one_r     <= h_one_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // side info that travels with the payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_use_mem_r <= rd_mem;
      a_eor_r     <= eor;
      a_eoi_r     <= eoi;
      out_eor_r   <= a_eor_r;
      out_eoi_r   <= a_eoi_r;
    end
  end

  // lane control group
  always_comb begin
    ctrl.acc_load = acc_load;
    ctrl.a_load   = en;
    ctrl.b_load   = en;
    ctrl.w_one    = w_one_r;
    ctrl.use_mem  = a_use_mem_r;
  end

  // channel lanes
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    rbd_lane u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .pix      (in_tdata[k*CH_BITS +: CH_BITS]),
      .mem_pair (mem_rdata[k*LANE_BITS +: LANE_BITS]),
      .hsum     (hsum_all[k*LANE_BITS +: LANE_BITS]),
      .avg      (avg_all[k*CH_BITS +: CH_BITS])
    );
  end

  // pair sums of even rows
  rbd_line_store #(
    .DEPTH (DEPTH),
    .WIDTH (MW),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (en),
    .we    (store_we),
    .addr  (x),
    .wdata (hsum_all),
    .rdata (mem_rdata)
  );

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = avg_all;
  assign out_tlast  = out_eor_r;
  assign out_tuser  = out_eoi_r;

endmodule

FILE: src/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker: port-level checks of the 2x2 box downsampler
// Watches the top-level channels over time; attached by bind.
// ----------------------------------------------------------------------------
module rbd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rbd_pkg::PIX_BITS-1:0]  out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // end of image is always also end of row
  a_eoi_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of image without end of row");

  // input is never blocked while the output register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rgba_box_downsample_2x2 rbd_checker u_rbd_checker (.*);

FILE: dv/tb_rgba_box_downsample_2x2.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgba_box_downsample_2x2: self-checking bench for the 2x2 box downsampler
// A short table of directed pixels and geometry writes comes first. It is
// followed by the leading part of oversized-geometry images and then many
// small random images, some of them cut off mid-image. A local mip predictor
// tracks the raster position, the even-column pixel and the pair-sum line.
// It queues each expected box average, and every output transaction is
// checked against the oldest entry. The sender runs in bursts, the receiver
// stalls on its own pattern, and one long receiver hold backs up the pipe.
// ----------------------------------------------------------------------------
module tb_rgba_box_downsample_2x2;
  import rbd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LINE_PAIRS  = DEFAULT_MAX_WIDTH / 2;
  localparam int HOLD_CYCLES = 400;
  localparam int WIDE_ITEMS  = 200;
  localparam int TALL_ITEMS  = 128;
  localparam int RAND_ITEMS  = 1100;
  localparam int MAX_RUN     = 512;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct packed {
    rgba_t color;
    logic  end_of_row;
    logic  end_of_image;
  } box_out_t;

  typedef enum {STEP_CFG, STEP_PIXEL} step_kind_t;
  typedef enum {RDY_OPEN, RDY_RANDOM, RDY_PATTERN} rdy_mode_t;

  typedef struct {
    step_kind_t    kind;
    cfg_reg_t      reg_idx;
    logic [12:0]   value;
    rgba_t         pix;
    bit            typed;
    box_out_t      want;
  } step_t;

  // clock, reset and block inputs, all known from time zero
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [PIX_BITS-1:0]  in_tdata   = '0;
  logic                 out_tready = 1'b0;
  logic                 cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_SRC_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [PIX_BITS-1:0]  out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;

  // predictor state
  logic [12:0]          img_w_reg;
  logic [12:0]          img_h_reg;
  int unsigned          col_pos;
  int unsigned          row_pos;
  logic [3:0][8:0]      even_pixel;
  logic [3:0][8:0]      pair_line [LINE_PAIRS];
  bit                   pixel_counted;

  box_out_t             pending_boxes [$];
  int                   mismatch_count = 0;
  int                   cycle_count    = 0;
  int                   burst_left     = 0;
  bit                   hold_go        = 1'b0;

  rgba_box_downsample_2x2 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // red, green, blue, alpha
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // red, green, blue, alpha
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),  // end_of_image
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // effective dimension: zero acts as one, large values saturate
  function automatic int unsigned eff_dim(input logic [12:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void clear_geometry();
    img_w_reg  = 13'd1;
    img_h_reg  = 13'd1;
    col_pos    = 0;
    row_pos    = 0;
    even_pixel = '0;
    foreach (pair_line[i]) pair_line[i] = '0;
  endfunction

  // mip predictor: one source pixel in, at most one box average out
  function automatic bit predict_box(input rgba_t px, output box_out_t res);
    int unsigned     w, h, c, r, dst_w, dst_h, x, y;
    logic [3:0][8:0] pl, hsum, upper;
    logic [3:0][7:0] avg;
    logic [10:0]     s;
    bit              have_pair, have_out;
    w = eff_dim(img_w_reg, DEFAULT_MAX_WIDTH);
    h = eff_dim(img_h_reg, HEIGHT_LIMIT);
    c = col_pos;
    r = row_pos;
    dst_w = (w == 1) ? 1 : w / 2;
    dst_h = (h == 1) ? 1 : h / 2;
    for (int k = 0; k < NUM_LANES; k++) pl[k] = {1'b0, px[8*k +: 8]};
    hsum = '0;
    upper = '0;
    have_pair = 1'b0;
    have_out = 1'b0;
    x = 0;
    y = 0;
    res = '0;
    // trailing odd column or row is taken and dropped
    pixel_counted = !((w > 1 && c[0] == 1'b0 && c + 1 >= w) ||
                      (h > 1 && r[0] == 1'b0 && r + 1 >= h));
    // horizontal pair
    if (w == 1) begin
      for (int k = 0; k < NUM_LANES; k++) hsum[k] = pl[k] + pl[k];
      have_pair = 1'b1;
    end else if (c[0] == 1'b0) begin
      if (c + 1 < w) even_pixel = pl;
    end else begin
      for (int k = 0; k < NUM_LANES; k++) hsum[k] = even_pixel[k] + pl[k];
      have_pair = 1'b1;
      x = c >> 1;
    end
    // vertical pair through the line store
    if (have_pair) begin
      if (h == 1) begin
        upper = hsum;
        have_out = 1'b1;
      end else if (r[0] == 1'b0) begin
        if (r + 1 < h) pair_line[x] = hsum;
      end else begin
        upper = pair_line[x];
        have_out = 1'b1;
        y = r >> 1;
      end
    end
    if (have_out) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        s = upper[k] + hsum[k];
        avg[k] = s[9:2];
      end
      res.color = avg;
      res.end_of_row = (x + 1 == dst_w);
      res.end_of_image = (x + 1 == dst_w) && (y + 1 == dst_h);
    end
    // raster advance with wrap at image end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
    return have_out;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgba_t rand_pixel();
    rgba_t p;
    p.red   = rand_channel();
    p.green = rand_channel();
    p.blue  = rand_channel();
    p.alpha = rand_channel();
    return p;
  endfunction

  function automatic step_t pix_row(input rgba_t p);
    step_t s;
    s.kind = STEP_PIXEL;
    s.reg_idx = REG_SRC_WIDTH;
    s.value = '0;
    s.pix = p;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t pix_want(input rgba_t p, input rgba_t c, input bit eor,
                                     input bit eoi);
    step_t s;
    s = pix_row(p);
    s.typed = 1'b1;
    s.want = '{color: c, end_of_row: eor, end_of_image: eoi};
    return s;
  endfunction

  function automatic step_t cfg_row(input cfg_reg_t idx, input logic [12:0] v);
    step_t s;
    s = pix_row('0);
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.value = v;
    return s;
  endfunction

  // offer one pixel, wait for its transaction, then maybe open a gap
  task automatic send_pixel(input rgba_t px, input bit typed, input box_out_t want);
    box_out_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    if (predict_box(px, res) || typed) pending_boxes.push_back(typed ? want : res);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 20);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // register write once the pipe has drained
  task automatic write_reg(input cfg_reg_t idx, input logic [12:0] v);
    in_tvalid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    if (idx == REG_SRC_WIDTH) img_w_reg = v;
    else img_h_reg = v;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic send_images(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel(), 1'b0, '0);
  endtask

  // receiver: ready pattern of its own plus one long hold
  initial begin
    int        run_left;
    int        hold_left;
    int        tick;
    bit        hold_done;
    rdy_mode_t mode;
    run_left = 0;
    hold_left = 0;
    tick = 0;
    hold_done = 1'b0;
    mode = RDY_OPEN;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (run_left == 0) begin
        mode = rdy_mode_t'($urandom_range(0, 2));
        run_left = $urandom_range(10, 150);
      end
      run_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          RDY_OPEN:   out_tready <= 1'b1;
          RDY_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
          default:    out_tready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    box_out_t exp_box;
    box_out_t got_box;
    if (rst_n && out_tvalid && out_tready) begin
      got_box = '{color: out_tdata, end_of_row: out_tlast, end_of_image: out_tuser};
      if (pending_boxes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: got rgba=%08h eor=%0b eoi=%0b",
                   got_box.color, got_box.end_of_row, got_box.end_of_image);
      end else begin
        exp_box = pending_boxes.pop_front();
        if (got_box.color.red !== exp_box.color.red ||
            got_box.color.green !== exp_box.color.green ||
            got_box.color.blue !== exp_box.color.blue ||
            got_box.color.alpha !== exp_box.color.alpha ||
            got_box.end_of_row !== exp_box.end_of_row ||
            got_box.end_of_image !== exp_box.end_of_image) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp r=%02h g=%02h b=%02h a=%02h eor=%0b eoi=%0b",
                     exp_box.color.red, exp_box.color.green, exp_box.color.blue,
                     exp_box.color.alpha, exp_box.end_of_row, exp_box.end_of_image);
            $display("          got r=%02h g=%02h b=%02h a=%02h eor=%0b eoi=%0b",
                     got_box.color.red, got_box.color.green, got_box.color.blue,
                     got_box.color.alpha, got_box.end_of_row, got_box.end_of_image);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    step_t       directed [$];
    int unsigned rand_items;
    int unsigned ew, eh, images, count;
    int          spin;
    int          sel;
    clear_geometry();
    rand_items = 0;
    spin = 0;

    // 1x1 after reset passes pixels through, then zero geometry acts as one
    directed.push_back(pix_want(32'hffffffff, 32'hffffffff, 1'b1, 1'b1));
    directed.push_back(pix_want(32'h00000000, 32'h00000000, 1'b1, 1'b1));
    directed.push_back(pix_want(32'h8001_7ffe, 32'h8001_7ffe, 1'b1, 1'b1));
    directed.push_back(cfg_row(REG_SRC_WIDTH, 13'd0));
    directed.push_back(cfg_row(REG_SRC_HEIGHT, 13'd0));
    directed.push_back(pix_want(32'h12345678, 32'h12345678, 1'b1, 1'b1));
    // 2x2 full scale, then truncation of the sum
    directed.push_back(cfg_row(REG_SRC_WIDTH, 13'd2));
    directed.push_back(cfg_row(REG_SRC_HEIGHT, 13'd2));
    repeat (3) directed.push_back(pix_row(32'hffffffff));
    directed.push_back(pix_want(32'hffffffff, 32'hffffffff, 1'b1, 1'b1));
    directed.push_back(pix_row(32'h01020303));
    directed.push_back(pix_row(32'h00010000));
    directed.push_back(pix_row(32'hff000001));
    directed.push_back(pix_row(32'h00ff0001));
    // trailing odd column, then trailing odd row
    directed.push_back(cfg_row(REG_SRC_WIDTH, 13'd3));
    for (int i = 0; i < 6; i++) directed.push_back(pix_row(32'h10203040 * (i + 1)));
    directed.push_back(cfg_row(REG_SRC_WIDTH, 13'd2));
    directed.push_back(cfg_row(REG_SRC_HEIGHT, 13'd3));
    for (int i = 0; i < 6; i++) directed.push_back(pix_row(32'hf1e2d3c4 - 32'h11111111 * i));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == STEP_CFG) write_reg(directed[i].reg_idx, directed[i].value);
      else send_pixel(directed[i].pix, directed[i].typed, directed[i].want);
    end

    // oversized width on a single row, with the long receiver hold
    write_reg(REG_SRC_HEIGHT, 13'd1);
    write_reg(REG_SRC_WIDTH, 13'($urandom_range(DEFAULT_MAX_WIDTH + 1, 8191)));
    hold_go = 1'b1;
    send_images(WIDE_ITEMS);
    // oversized height on a single column
    write_reg(REG_SRC_WIDTH, 13'd1);
    write_reg(REG_SRC_HEIGHT, 13'd8191);
    send_images(TALL_ITEMS);

    // random geometries, mostly whole images, some cut off mid-image
    while (rand_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 2) begin
        write_reg(REG_SRC_WIDTH, 13'($urandom_range(64, 160)));
        write_reg(REG_SRC_HEIGHT, 13'($urandom_range(2, 3)));
      end else begin
        case (sel)
          0: begin
            ew = $urandom_range(0, 1);
            eh = $urandom_range(0, 9);
          end
          1: begin
            ew = $urandom_range(0, 16);
            eh = $urandom_range(0, 1);
          end
          default: begin
            ew = $urandom_range(2, 17);
            eh = $urandom_range(2, 11);
          end
        endcase
        case ($urandom_range(0, 3))
          0: write_reg(REG_SRC_WIDTH, 13'(ew));
          1: write_reg(REG_SRC_HEIGHT, 13'(eh));
          2: begin
            write_reg(REG_SRC_HEIGHT, 13'(eh));
            write_reg(REG_SRC_WIDTH, 13'(ew));
          end
          default: begin
            write_reg(REG_SRC_WIDTH, 13'(ew));
            write_reg(REG_SRC_HEIGHT, 13'(eh));
          end
        endcase
      end
      ew = eff_dim(img_w_reg, DEFAULT_MAX_WIDTH);
      eh = eff_dim(img_h_reg, HEIGHT_LIMIT);
      images = (ew * eh > 300) ? 1 : $urandom_range(1, 3);
      count = ew * eh * images;
      // a large leftover geometry is only started, not finished
      if (count > MAX_RUN) count = MAX_RUN;
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      for (int unsigned i = 0; i < count; i++) begin
        send_pixel(rand_pixel(), 1'b0, '0);
        if (pixel_counted) rand_items++;
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (pending_boxes.size() != 0 && spin < 50000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (pending_boxes.size() != 0) begin
      mismatch_count++;
      $display("%0d expected transactions never arrived", pending_boxes.size());
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/rbd_pkg.sv
src/rbd_lane.sv
src/rbd_line_store.sv
src/rgba_box_downsample_2x2.sv
src/rbd_checker.sv
dv/tb_rgba_box_downsample_2x2.sv
